// ----- rtl/tfa_pkg.sv -----
// Package for the thermocouple frame averager.
// Frame field positions, field widths, fault codes and the fault decode.
// No dependencies.
package tfa_pkg;

    // Frame layout
    localparam int PROBE_W    = 14;
    localparam int PROBE_LSB  = 18;
    localparam int JUNC_W     = 12;
    localparam int JUNC_LSB   = 4;
    localparam int FAULT_BIT  = 16;
    localparam int OPEN_BIT   = 0;
    localparam int GND_BIT    = 1;
    localparam int VCC_BIT    = 2;

    // Result widths
    localparam int PROBE_AVG_W = 18;
    localparam int JUNC_AVG_W  = 16;
    localparam int FAULT_W     = 3;

    // Extra fraction bits on the means
    localparam int FRAC_W = 4;

    typedef logic [FAULT_W-1:0] fault_t;

    localparam fault_t FAULT_NONE    = 3'd0;
    localparam fault_t FAULT_OPEN    = 3'd1;
    localparam fault_t FAULT_GND     = 3'd2;
    localparam fault_t FAULT_VCC     = 3'd3;
    localparam fault_t FAULT_UNKNOWN = 3'd4;

    // Priority decode of the fault flags of one frame
    function automatic fault_t fault_decode(input logic [31:0] f);
        fault_t code;
        if (!f[FAULT_BIT])
        begin
            code = FAULT_NONE;
        end
        else if (f[OPEN_BIT])
        begin
            code = FAULT_OPEN;
        end
        else if (f[GND_BIT])
        begin
            code = FAULT_GND;
        end
        else if (f[VCC_BIT])
        begin
            code = FAULT_VCC;
        end
        else
        begin
            code = FAULT_UNKNOWN;
        end
        return code;
    endfunction

endpackage

// ----- rtl/thermocouple_frame_averager_core.sv -----
// Thermocouple frame averager: accumulates probe and cold-junction fields
// over SAMPLES frames and gives both means and the last frame's fault code.
// Depends on tfa_pkg.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-----------------------------------
//  input   | in        | in_valid / in_stall | frame[31:0]
//  output  | out       | out_valid/out_stall | probe_average, junction_average,
//          |           |                     | fault_code
//
// While in_stall is low one frame is taken every cycle; the accumulators add one field each per frame.
// After the closing frame of a block is taken, the result passes through the total register,
// the reciprocal multiply register and the sign restore into the output register before out_valid rises.
// in_stall rises only when the total register holds a block, the stages behind it
// are all full and out_stall is high, so frames keep coming while a result waits.
// rst_n clears the sums, the count and all valid bits; payload is not reset.
module thermocouple_frame_averager_core
    import tfa_pkg::*;
#(
    parameter int SAMPLES = 20
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [31:0]                   frame,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [PROBE_AVG_W-1:0] probe_average,
    output logic signed [JUNC_AVG_W-1:0]  junction_average,
    output logic [FAULT_W-1:0]            fault_code
);

    // Exact sum widths for SAMPLES fields
    localparam int LOG_S = $clog2(SAMPLES);
    localparam int PW    = PROBE_W + LOG_S;
    localparam int JW    = JUNC_W + LOG_S;
    localparam int CNT_W = (SAMPLES > 1) ? LOG_S : 1;

    // Divide by SAMPLES as a multiply by a rounded-up reciprocal; exact for
    // magnitudes below 2^(PW+FRAC_W) when the shift has LOG_S spare bits.
    localparam int PMAG_W = PW + FRAC_W;
    localparam int JMAG_W = JW + FRAC_W;
    localparam int K      = PMAG_W + LOG_S;
    localparam int M_W    = K + 1;
    localparam logic [M_W-1:0] RECIP =
        M_W'(((64'd1 << K) + 64'(SAMPLES) - 64'd1) / 64'(SAMPLES));
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(SAMPLES - 1);

    // Accumulator state
    logic signed [PW-1:0] psum_reg;
    logic signed [JW-1:0] jsum_reg;
    logic [CNT_W-1:0]     cnt_reg;

    // Stage A: block totals
    logic                 a_valid_reg;
    logic signed [PW-1:0] a_ptot_reg;
    logic signed [JW-1:0] a_jtot_reg;
    fault_t               a_fault_reg;

    // Stage B: reciprocal products
    logic                     b_valid_reg;
    logic [PMAG_W+M_W-1:0]    b_pprod_reg;
    logic [JMAG_W+M_W-1:0]    b_jprod_reg;
    logic                     b_pneg_reg;
    logic                     b_jneg_reg;
    fault_t                   b_fault_reg;

    // Stage C: output register
    logic                          c_valid_reg;
    logic signed [PROBE_AVG_W-1:0] c_pavg_reg;
    logic signed [JUNC_AVG_W-1:0]  c_javg_reg;
    fault_t                        c_fault_reg;

    logic                 c_ready;
    logic                 b_ready;
    logic                 a_ready;
    logic                 in_fire;
    logic                 last;
    logic signed [PW-1:0] p_field;
    logic signed [JW-1:0] j_field;
    logic signed [PW-1:0] ptot_next;
    logic signed [JW-1:0] jtot_next;
    logic [PW-1:0]        pabs;
    logic [JW-1:0]        jabs;
    logic [PMAG_W-1:0]    pmag;
    logic [JMAG_W-1:0]    jmag;
    logic [PROBE_AVG_W-1:0] pq;
    logic [JUNC_AVG_W-1:0]  jq;

    // Stage handshakes
    assign c_ready  = !c_valid_reg || !out_stall;
    assign b_ready  = !b_valid_reg || c_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_stall = !a_ready;
    assign in_fire  = in_valid && !in_stall;
    assign last     = (cnt_reg == LAST_CNT);

    // Field extraction and running totals
    assign p_field   = PW'($signed(frame[PROBE_LSB +: PROBE_W]));
    assign j_field   = JW'($signed(frame[JUNC_LSB +: JUNC_W]));
    assign ptot_next = psum_reg + p_field;
    assign jtot_next = jsum_reg + j_field;

    // Accumulators and block count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            psum_reg <= '0;
            jsum_reg <= '0;
            cnt_reg  <= '0;
        end
        else if (in_fire)
        begin
            if (last)
            begin
                psum_reg <= '0;
                jsum_reg <= '0;
                cnt_reg  <= '0;
            end
            else
            begin
                psum_reg <= ptot_next;
                jsum_reg <= jtot_next;
                cnt_reg  <= cnt_reg + 1'b1;
            end
        end
    end

    // Stage A: capture totals of a finished block
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (in_fire && last)
        begin
            a_valid_reg <= 1'b1;
        end
        else if (b_ready)
        begin
            a_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && last)
        begin
            a_ptot_reg  <= ptot_next;
            a_jtot_reg  <= jtot_next;
            a_fault_reg <= fault_decode(frame);
        end
    end

    // Magnitudes scaled by the fraction bits
    assign pabs = a_ptot_reg[PW-1] ? PW'(-a_ptot_reg) : PW'(a_ptot_reg);
    assign jabs = a_jtot_reg[JW-1] ? JW'(-a_jtot_reg) : JW'(a_jtot_reg);
    assign pmag = {pabs, {FRAC_W{1'b0}}};
    assign jmag = {jabs, {FRAC_W{1'b0}}};

    // Stage B: multiply by the reciprocal
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (b_ready)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_ready && a_valid_reg)
        begin
            b_pprod_reg <= (PMAG_W+M_W)'(pmag) * (PMAG_W+M_W)'(RECIP);
            b_jprod_reg <= (JMAG_W+M_W)'(jmag) * (JMAG_W+M_W)'(RECIP);
            b_pneg_reg  <= a_ptot_reg[PW-1];
            b_jneg_reg  <= a_jtot_reg[JW-1];
            b_fault_reg <= a_fault_reg;
        end
    end

    // Quotients, then sign restore (truncation toward zero)
    assign pq = b_pprod_reg[K +: PROBE_AVG_W];
    assign jq = b_jprod_reg[K +: JUNC_AVG_W];

    // Stage C: output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else if (c_ready)
        begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_ready && b_valid_reg)
        begin
            c_pavg_reg  <= b_pneg_reg ? $signed(-pq) : $signed(pq);
            c_javg_reg  <= b_jneg_reg ? $signed(-jq) : $signed(jq);
            c_fault_reg <= b_fault_reg;
        end
    end

    assign out_valid        = c_valid_reg;
    assign probe_average    = c_pavg_reg;
    assign junction_average = c_javg_reg;
    assign fault_code       = c_fault_reg;

`ifndef SYNTH
    // Input stalls only when the total register is blocked
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (a_valid_reg && b_valid_reg && c_valid_reg && out_stall))
        else $error("in_stall without a full pipeline");

    // Block count stays below SAMPLES
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= LAST_CNT)
        else $error("frame count out of range");

    // A total appears only after the closing frame of a block
    a_total_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(a_valid_reg) |-> $past(in_fire && last))
        else $error("block total without closing frame");

    // A result appears only after a product was held
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(c_valid_reg) |-> $past(b_valid_reg))
        else $error("result without product");
`endif

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for thermocouple_frame_averager_core.
// It predicts every block mean from the frames that go in and checks each result as it comes out.
// Depends on tfa_pkg and the core RTL.
module testbench
    import tfa_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SAMPLES        = 20;
    localparam int CLK_PERIOD     = 12;
    localparam int RANDOM_BLOCKS  = 52;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 5000;

    typedef enum int {STYLE_RANDOM, STYLE_MAX, STYLE_MIN, STYLE_NEAR_ZERO} block_style_t;

    typedef struct {
        logic signed [PROBE_AVG_W-1:0] probe;
        logic signed [JUNC_AVG_W-1:0]  junction;
        fault_t                        fault;
    } block_mean_t;

    // Keeps running sums, predicts each block mean and checks the outputs
    class mean_tracker;
        int          block_len;
        int          probe_acc;
        int          junction_acc;
        int          frames_in_block;
        int          frames_taken;
        int          means_checked;
        int          mismatches;
        block_mean_t pending_means[$];

        function new(int samples);
            block_len       = samples;
            probe_acc       = 0;
            junction_acc    = 0;
            frames_in_block = 0;
            frames_taken    = 0;
            means_checked   = 0;
            mismatches      = 0;
        endfunction

        function int pending();
            return pending_means.size();
        endfunction

        // Take one accepted frame; queue a mean when it closes a block
        function void note_frame(logic [31:0] f);
            logic signed [PROBE_W-1:0] probe_field;
            logic signed [JUNC_W-1:0]  junction_field;
            block_mean_t               mean;
            int                        probe_scaled;
            int                        junction_scaled;
            probe_field    = f[PROBE_LSB +: PROBE_W];
            junction_field = f[JUNC_LSB +: JUNC_W];
            probe_acc     += probe_field;
            junction_acc  += junction_field;
            frames_in_block++;
            frames_taken++;
            if (frames_in_block == block_len)
            begin
                // integer division truncates toward zero
                probe_scaled    = (probe_acc * (1 << FRAC_W)) / block_len;
                junction_scaled = (junction_acc * (1 << FRAC_W)) / block_len;
                mean.probe      = probe_scaled[PROBE_AVG_W-1:0];
                mean.junction   = junction_scaled[JUNC_AVG_W-1:0];
                // fault comes from the closing frame only
                if (!f[FAULT_BIT])
                    mean.fault = FAULT_NONE;
                else if (f[OPEN_BIT])
                    mean.fault = FAULT_OPEN;
                else if (f[GND_BIT])
                    mean.fault = FAULT_GND;
                else if (f[VCC_BIT])
                    mean.fault = FAULT_VCC;
                else
                    mean.fault = FAULT_UNKNOWN;
                pending_means.push_back(mean);
                probe_acc       = 0;
                junction_acc    = 0;
                frames_in_block = 0;
            end
        endfunction

        // Compare one accepted result with the oldest predicted mean
        function void check_mean(logic signed [PROBE_AVG_W-1:0] probe,
                                 logic signed [JUNC_AVG_W-1:0] junction, fault_t fault);
            block_mean_t want;
            if (pending_means.size() == 0)
            begin
                $error("result with nothing expected: probe_average %0d junction_average %0d",
                       probe, junction);
                mismatches++;
                return;
            end
            want = pending_means.pop_front();
            means_checked++;
            if (probe !== want.probe)
            begin
                $error("probe_average: expected %0d, got %0d", want.probe, probe);
                mismatches++;
            end
            if (junction !== want.junction)
            begin
                $error("junction_average: expected %0d, got %0d", want.junction, junction);
                mismatches++;
            end
            if (fault !== want.fault)
            begin
                $error("fault_code: expected %0d, got %0d", want.fault, fault);
                mismatches++;
            end
        endfunction
    endclass

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_stall;
    logic [31:0]                   frame;
    logic                          out_valid;
    logic                          out_stall;
    logic signed [PROBE_AVG_W-1:0] probe_average;
    logic signed [JUNC_AVG_W-1:0]  junction_average;
    fault_t                        fault_code;

    mean_tracker tracker = new(SAMPLES);
    bit          tx_free;
    bit          rx_free;
    bit          rx_hold_req;
    int          quiet_cycles;

    thermocouple_frame_averager_core #(
        .SAMPLES(SAMPLES)
    ) u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .frame           (frame),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .probe_average   (probe_average),
        .junction_average(junction_average),
        .fault_code      (fault_code)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #(CLK_PERIOD / 2) clk = ~clk;
        end
    end

    // Build a frame: random filler, chosen temperature fields
    function automatic logic [31:0] pack_frame(logic [PROBE_W-1:0] probe,
                                               logic [JUNC_W-1:0] junction);
        logic [31:0] f;
        f = $urandom;
        f[PROBE_LSB +: PROBE_W] = probe;
        f[JUNC_LSB +: JUNC_W]   = junction;
        return f;
    endfunction

    // Force the fault bits of a frame so that it decodes to the given code
    function automatic logic [31:0] with_fault(logic [31:0] f, fault_t code);
        logic [31:0] g;
        g = f;
        g[FAULT_BIT] = (code != FAULT_NONE);
        case (code)
            FAULT_OPEN:    g[OPEN_BIT] = 1'b1;
            FAULT_GND:     {g[GND_BIT], g[OPEN_BIT]} = 2'b10;
            FAULT_VCC:     {g[VCC_BIT], g[GND_BIT], g[OPEN_BIT]} = 3'b100;
            FAULT_UNKNOWN: {g[VCC_BIT], g[GND_BIT], g[OPEN_BIT]} = 3'b000;
            default:       ;
        endcase
        return g;
    endfunction

    // Offer one frame, with an occasional gap before it while tx_free is clear
    task automatic send_frame(input logic [31:0] f);
        if (!tx_free && $urandom_range(99) < 12)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge clk);
        end
        frame    <= f;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
    endtask

    // One block of SAMPLES frames in the given style, closing frame carries the fault
    task automatic send_block(input block_style_t style, input fault_t code);
        logic [31:0]        f;
        logic [PROBE_W-1:0] probe;
        logic [JUNC_W-1:0]  junction;
        for (int i = 0; i < SAMPLES; i++)
        begin
            case (style)
                STYLE_MAX:
                begin
                    probe    = {1'b0, {(PROBE_W-1){1'b1}}};
                    junction = {1'b0, {(JUNC_W-1){1'b1}}};
                end
                STYLE_MIN:
                begin
                    probe    = {1'b1, {(PROBE_W-1){1'b0}}};
                    junction = {1'b1, {(JUNC_W-1){1'b0}}};
                end
                STYLE_NEAR_ZERO:
                begin
                    probe    = PROBE_W'($urandom_range(6) - 3);
                    junction = JUNC_W'($urandom_range(6) - 3);
                end
                default:
                begin
                    probe    = PROBE_W'($urandom);
                    junction = JUNC_W'($urandom);
                end
            endcase
            f = pack_frame(probe, junction);
            if (i == SAMPLES - 1)
                f = with_fault(f, code);
            send_frame(f);
        end
    endtask

    // Receiver: random stalls, free-running stretch, one long hold-off
    initial
    begin
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (rx_free)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(99) < 15);
        end
    end

    // Monitor both channels and watch for a hang
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                tracker.note_frame(frame);
            if (out_valid && !out_stall)
                tracker.check_mean(probe_average, junction_average, fault_code);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // Main sequence
    initial
    begin
        logic [31:0] f;
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        frame        <= '0;
        tx_free      = 1'b0;
        rx_free      = 1'b0;
        rx_hold_req  = 1'b0;
        quiet_cycles = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed block: full-scale fields, all-ones and all-zeros frames,
        // fault flags on intermediate frames (ignored), reserved bits set
        for (int i = 0; i < SAMPLES; i++)
        begin
            case (i % 4)
                0:       f = 32'hFFFF_FFFF;
                1:       f = 32'h0000_0000;
                2:       f = pack_frame(14'h1FFF, 12'h7FF) | 32'h0003_0008;
                default: f = pack_frame(14'h2000, 12'h800);
            endcase
            if (i == SAMPLES - 1)
                f = with_fault(pack_frame(14'h1FFF, 12'h800), FAULT_OPEN);
            send_frame(f);
        end

        // Random blocks: the first four fixed, the rest with every fault code equally likely
        for (int b = 0; b < RANDOM_BLOCKS; b++)
        begin
            if (b == 10)
                rx_hold_req = 1'b1;
            tx_free = (b >= 15 && b < 25);
            rx_free = (b >= 15 && b < 25);
            if (b == 30)
            begin
                // drain everything before going on
                in_valid <= 1'b0;
                @(posedge clk);
                while (tracker.pending() != 0)
                begin
                    @(posedge clk);
                end
            end
            if (b < 4)
                send_block(block_style_t'(b), fault_t'(b));
            else
                send_block(block_style_t'($urandom_range(3)), fault_t'($urandom_range(4)));
        end
        in_valid <= 1'b0;

        // Drain and let the pipeline settle
        while (tracker.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);

        $display("Checked %0d block means from %0d frames (full-scale, near-zero, random).",
                 tracker.means_checked, tracker.frames_taken);
        $display("Covered all fault codes, a long output hold-off and a full drain pause.");
        if (tracker.mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/tfa_pkg.sv
rtl/thermocouple_frame_averager_core.sv
sim/testbench.sv
